@@ hw/rtl/replay_window_checker_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Replay window checker assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef REPLAY_WINDOW_CHECKER_UNIT_DEFINES_SVH
`define REPLAY_WINDOW_CHECKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RWC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rwc assertion failed");
`define RWC_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rwc forbidden condition");
`else
`define RWC_ASSERT(name, clk, rst_n, prop)
`define RWC_ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

@@ hw/rtl/rwc_pkg.sv @@
// ----------------------------------------------------------------------------
// Replay window checker package
// Shared widths, status codes and the bitmap request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rwc_pkg;

  localparam int WINDOW_BITS = 2048;
  localparam int IDX_W       = $clog2(WINDOW_BITS);
  localparam int BYTE_BITS   = 8;
  localparam int BIT_SEL_W   = $clog2(BYTE_BITS);
  localparam int BYTES       = WINDOW_BITS / BYTE_BITS;
  localparam int BYTE_ADDR_W = IDX_W - BIT_SEL_W;
  localparam int EXTENT_W    = IDX_W + 1;
  localparam int ID_W        = 32;
  localparam int TICK_W      = 32;
  localparam int STATUS_W    = 2;

  localparam logic [TICK_W-1:0] EXPIRE_TICKS_RESET = TICK_W'(1920);

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPT,
    ST_ZERO,
    ST_SEEN,
    ST_OLD
  } status_e;

  typedef struct packed {
    logic                   rd_en;
    logic [BYTE_ADDR_W-1:0] rd_addr;
    logic                   wr_en;
    logic [BYTE_ADDR_W-1:0] wr_addr;
    logic [BYTE_BITS-1:0]   wr_data;
    logic                   clr_all;
  } bm_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/rwc_bitmap.sv @@
// ----------------------------------------------------------------------------
// Replay window seen-bitmap
// Byte-wide synchronous memory, read data registered for the next cycle,
// with per-byte valid flags; an invalid byte reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_bitmap (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rwc_pkg::bm_req_t               req_i,
  output logic [rwc_pkg::BYTE_BITS-1:0]       rd_data_o
);

  logic [rwc_pkg::BYTE_BITS-1:0] mem_q [rwc_pkg::BYTES];
  logic [rwc_pkg::BYTES-1:0]     valid_q;
  logic [rwc_pkg::BYTES-1:0]     valid_d;
  logic [rwc_pkg::BYTE_BITS-1:0] rd_data_q;
  logic                          rd_valid_q;

  always_comb begin
    valid_d = req_i.clr_all ? '0 : valid_q;
    if (req_i.wr_en) begin
      valid_d[req_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_data_q & {rwc_pkg::BYTE_BITS{rd_valid_q}};

endmodule

`default_nettype wire

@@ hw/rtl/rwc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Replay window checker control
// Per-request sequencer: expiry check, classification, bitmap
// read-modify-write, skipped-flag clearing sweep and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwc_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [rwc_pkg::ID_W-1:0]         packet_id_i,
  input  wire logic [rwc_pkg::TICK_W-1:0]       now_tick_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [rwc_pkg::STATUS_W-1:0]          status_o,
  output logic [rwc_pkg::ID_W-1:0]              max_backtrack_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [rwc_pkg::TICK_W-1:0]       cfg_wdata_i,
  output rwc_pkg::bm_req_t                      bm_req_o,
  input  wire logic [rwc_pkg::BYTE_BITS-1:0]    bm_rd_data_i
);

  localparam int IDX_W       = rwc_pkg::IDX_W;
  localparam int BIT_SEL_W   = rwc_pkg::BIT_SEL_W;
  localparam int BYTE_BITS   = rwc_pkg::BYTE_BITS;
  localparam int BYTE_ADDR_W = rwc_pkg::BYTE_ADDR_W;
  localparam int EXTENT_W    = rwc_pkg::EXTENT_W;
  localparam int ID_W        = rwc_pkg::ID_W;
  localparam int TICK_W      = rwc_pkg::TICK_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_BT_CHK,
    S_SWEEP,
    S_FINISH
  } state_e;

  state_e                 state_q;
  logic [TICK_W-1:0]      expire_ticks_q;
  logic [ID_W-1:0]        highest_q;
  logic [ID_W-1:0]        floor_q;
  logic [IDX_W-1:0]       base_q;
  logic [EXTENT_W-1:0]    extent_q;
  logic [TICK_W-1:0]      expire_time_q;
  logic [ID_W-1:0]        largest_q;

  logic [ID_W-1:0]        id_q;
  logic [TICK_W-1:0]      now_q;
  logic                   zero_q;
  logic                   fwd_q;
  logic [ID_W-1:0]        delta_q;
  rwc_pkg::status_e       status_q;
  logic [BYTE_ADDR_W-1:0] bt_addr_q;
  logic [BIT_SEL_W-1:0]   bit_sel_q;

  logic [BYTE_ADDR_W-1:0] sw_addr_q;
  logic [BIT_SEL_W-1:0]   sw_low_q;
  logic                   sw_first_q;
  logic [EXTENT_W-1:0]    sw_rem_q;

  logic                   out_valid_q;
  rwc_pkg::status_e       out_status_q;
  logic [ID_W-1:0]        out_backtrack_q;

  logic [TICK_W-1:0]      tick_diff;
  logic [IDX_W-1:0]       new_base;
  logic [IDX_W-1:0]       bt_idx;
  logic                   in_win;
  logic                   bt_reject;
  logic [EXTENT_W:0]      ext_sum;
  logic [EXTENT_W-1:0]    ext_next;
  logic [BIT_SEL_W-1:0]   sw_low_eff;
  logic [BIT_SEL_W:0]     sw_span;
  logic                   sw_done;
  logic [BYTE_BITS-1:0]   sw_mask;
  logic [BYTE_BITS-1:0]   sw_set;
  logic [BYTE_BITS-1:0]   sw_byte;
  logic                   bt_seen;

  assign tick_diff = now_tick_i - expire_time_q;
  assign new_base  = base_q - delta_q[IDX_W-1:0];
  assign bt_idx    = base_q + delta_q[IDX_W-1:0];
  assign in_win    = delta_q < ID_W'(rwc_pkg::WINDOW_BITS);
  assign bt_reject = (delta_q >= ID_W'(extent_q)) || (id_q <= floor_q);
  assign ext_sum   = {1'b0, extent_q} + {1'b0, delta_q[EXTENT_W-1:0]};
  assign ext_next  = (ext_sum > (EXTENT_W+1)'(rwc_pkg::WINDOW_BITS)) ?
                     EXTENT_W'(rwc_pkg::WINDOW_BITS) : ext_sum[EXTENT_W-1:0];
  assign bt_seen   = bm_rd_data_i[bit_sel_q];

  assign sw_low_eff = sw_first_q ? sw_low_q : '0;
  assign sw_span    = (BIT_SEL_W+1)'(BYTE_BITS) - {1'b0, sw_low_eff};
  assign sw_done    = sw_rem_q <= EXTENT_W'(sw_span);
  assign sw_set     = sw_first_q ? (BYTE_BITS'(1) << sw_low_q) : '0;

  always_comb begin
    for (int b = 0; b < BYTE_BITS; b++) begin
      sw_mask[b] = (BIT_SEL_W'(b) >= sw_low_eff) &&
                   (EXTENT_W'(BIT_SEL_W'(b) - sw_low_eff) < sw_rem_q);
    end
  end

  assign sw_byte = (bm_rd_data_i & ~sw_mask) | sw_set;

  always_comb begin
    bm_req_o = '0;
    case (state_q)
      S_DECIDE: begin
        if (!zero_q && fwd_q) begin
          if (in_win) begin
            bm_req_o.rd_en   = 1'b1;
            bm_req_o.rd_addr = new_base[IDX_W-1:BIT_SEL_W];
          end else begin
            bm_req_o.clr_all = 1'b1;
            bm_req_o.wr_en   = 1'b1;
            bm_req_o.wr_addr = '0;
            bm_req_o.wr_data = BYTE_BITS'(1);
          end
        end else if (!zero_q && !bt_reject) begin
          bm_req_o.rd_en   = 1'b1;
          bm_req_o.rd_addr = bt_idx[IDX_W-1:BIT_SEL_W];
        end
      end
      S_BT_CHK: begin
        if (!bt_seen) begin
          bm_req_o.wr_en   = 1'b1;
          bm_req_o.wr_addr = bt_addr_q;
          bm_req_o.wr_data = bm_rd_data_i | (BYTE_BITS'(1) << bit_sel_q);
        end
      end
      S_SWEEP: begin
        bm_req_o.wr_en   = 1'b1;
        bm_req_o.wr_addr = sw_addr_q;
        bm_req_o.wr_data = sw_byte;
        if (!sw_done) begin
          bm_req_o.rd_en   = 1'b1;
          bm_req_o.rd_addr = sw_addr_q + BYTE_ADDR_W'(1);
        end
      end
      default: begin
        bm_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      expire_ticks_q  <= rwc_pkg::EXPIRE_TICKS_RESET;
      highest_q       <= '0;
      floor_q         <= '0;
      base_q          <= '0;
      extent_q        <= '0;
      expire_time_q   <= '0;
      largest_q       <= '0;
      id_q            <= '0;
      now_q           <= '0;
      zero_q          <= 1'b0;
      fwd_q           <= 1'b0;
      delta_q         <= '0;
      status_q        <= rwc_pkg::ST_ACCEPT;
      bt_addr_q       <= '0;
      bit_sel_q       <= '0;
      sw_addr_q       <= '0;
      sw_low_q        <= '0;
      sw_first_q      <= 1'b0;
      sw_rem_q        <= '0;
      out_valid_q     <= 1'b0;
      out_status_q    <= rwc_pkg::ST_ACCEPT;
      out_backtrack_q <= '0;
    end else begin
      if (cfg_we_i) begin
        expire_ticks_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            id_q  <= packet_id_i;
            now_q <= now_tick_i;
            if (!tick_diff[TICK_W-1]) begin
              floor_q <= highest_q;
            end
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          zero_q  <= (id_q == '0);
          fwd_q   <= (id_q > highest_q);
          delta_q <= (id_q > highest_q) ? (id_q - highest_q) : (highest_q - id_q);
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (zero_q) begin
            status_q <= rwc_pkg::ST_ZERO;
            state_q  <= S_FINISH;
          end else if (fwd_q) begin
            highest_q <= id_q;
            if (in_win) begin
              base_q     <= new_base;
              extent_q   <= ext_next;
              sw_addr_q  <= new_base[IDX_W-1:BIT_SEL_W];
              sw_low_q   <= new_base[BIT_SEL_W-1:0];
              sw_first_q <= 1'b1;
              sw_rem_q   <= delta_q[EXTENT_W-1:0];
              state_q    <= S_SWEEP;
            end else begin
              base_q   <= '0;
              extent_q <= EXTENT_W'(rwc_pkg::WINDOW_BITS);
              status_q <= rwc_pkg::ST_ACCEPT;
              state_q  <= S_FINISH;
            end
          end else begin
            if (delta_q > largest_q) begin
              largest_q <= delta_q;
            end
            if (bt_reject) begin
              status_q <= rwc_pkg::ST_OLD;
              state_q  <= S_FINISH;
            end else begin
              bt_addr_q <= bt_idx[IDX_W-1:BIT_SEL_W];
              bit_sel_q <= bt_idx[BIT_SEL_W-1:0];
              state_q   <= S_BT_CHK;
            end
          end
        end
        S_BT_CHK: begin
          status_q <= bt_seen ? rwc_pkg::ST_SEEN : rwc_pkg::ST_ACCEPT;
          state_q  <= S_FINISH;
        end
        S_SWEEP: begin
          if (sw_done) begin
            status_q <= rwc_pkg::ST_ACCEPT;
            state_q  <= S_FINISH;
          end else begin
            sw_addr_q  <= sw_addr_q + BYTE_ADDR_W'(1);
            sw_first_q <= 1'b0;
            sw_rem_q   <= sw_rem_q - EXTENT_W'(sw_span);
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q     <= 1'b1;
            out_status_q    <= status_q;
            out_backtrack_q <= largest_q;
            if (status_q == rwc_pkg::ST_ACCEPT) begin
              expire_time_q <= now_q + expire_ticks_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign max_backtrack_o = out_backtrack_q;

endmodule

`default_nettype wire

@@ hw/rtl/replay_window_checker_unit.sv @@
// Flow: zero, too-old and far-jump IDs are settled in the decide state; backward
//   IDs add a bitmap check, an in-window forward jump a sweep of N bitmap bytes.
// Requests: a new one is taken only after the last result is registered and
//   not stalled; N runs from 1 to 257, one byte read and written per sweep step.
// Reset: asynchronous, active low; clears all window state and the bitmap
//   valid flags at once, with no clearing pass.
// ----------------------------------------------------------------------------
// Replay window checker top level
// Anti-replay sliding window check of received packet IDs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "replay_window_checker_unit_defines.svh"

module replay_window_checker_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [rwc_pkg::ID_W-1:0]         packet_id_i,
  input  wire logic [rwc_pkg::TICK_W-1:0]       now_tick_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [rwc_pkg::STATUS_W-1:0]          status_o,
  output logic [rwc_pkg::ID_W-1:0]              max_backtrack_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [rwc_pkg::TICK_W-1:0]       cfg_wdata_i
);

  rwc_pkg::bm_req_t              bm_req;
  logic [rwc_pkg::BYTE_BITS-1:0] bm_rd_data;

  rwc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .packet_id_i     (packet_id_i),
    .now_tick_i      (now_tick_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .max_backtrack_o (max_backtrack_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .bm_req_o        (bm_req),
    .bm_rd_data_i    (bm_rd_data)
  );

  rwc_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (bm_req),
    .rd_data_o (bm_rd_data)
  );

  `RWC_ASSERT(a_busy_after_request, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `RWC_ASSERT_NEVER(a_no_rw_collision, clk_i, rst_ni, bm_req.rd_en && bm_req.wr_en && (bm_req.rd_addr == bm_req.wr_addr))
  `RWC_ASSERT(a_clear_sets_base, clk_i, rst_ni, bm_req.clr_all |-> (bm_req.wr_en && (bm_req.wr_addr == '0)))
  `RWC_ASSERT(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_ready_o))

endmodule

`default_nettype wire

@@ dv/tb_replay_window_checker_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Replay window checker regression bench
// Drives packet ID / tick requests with random gaps on both handshakes, runs
// them through a cycle-free model of the anti-replay window and compares
// every status and max-backtrack result in order. Directed cases cover zero
// IDs, steps, in-window and far jumps, duplicates, stale IDs, floor expiry
// and tick wrap; random phases sweep several expiry settings.
// ----------------------------------------------------------------------------

module tb_replay_window_checker_unit;

  typedef struct {
    rwc_pkg::status_e         status;
    logic [rwc_pkg::ID_W-1:0] max_backtrack;
  } verdict_t;

  logic                         clk_i;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  logic [rwc_pkg::ID_W-1:0]     packet_id_i   = '0;
  logic [rwc_pkg::TICK_W-1:0]   now_tick_i    = '0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  logic [rwc_pkg::STATUS_W-1:0] status_o;
  logic [rwc_pkg::ID_W-1:0]     max_backtrack_o;
  logic                         cfg_we_i      = 1'b0;
  logic [rwc_pkg::TICK_W-1:0]   cfg_wdata_i   = '0;

  logic [rwc_pkg::ID_W-1:0]        top_id_q       = '0;
  logic [rwc_pkg::ID_W-1:0]        floor_id_q     = '0;
  logic [rwc_pkg::IDX_W-1:0]       base_q         = '0;
  logic [rwc_pkg::EXTENT_W-1:0]    extent_q       = '0;
  logic [rwc_pkg::WINDOW_BITS-1:0] seen_map       = '0;
  logic [rwc_pkg::TICK_W-1:0]      expiry_q       = '0;
  logic [rwc_pkg::ID_W-1:0]        backtrack_q    = '0;
  logic [rwc_pkg::TICK_W-1:0]      expire_ticks_q = rwc_pkg::EXPIRE_TICKS_RESET;
  logic [rwc_pkg::TICK_W-1:0]      tick_q         = '0;

  verdict_t pending_verdicts[$];
  int       mismatch_count = 0;
  int       request_count  = 0;
  int       setting_count  = 0;
  int       status_hits[4] = '{0, 0, 0, 0};
  bit       steady_flow    = 1'b0;

  replay_window_checker_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .packet_id_i     (packet_id_i),
    .now_tick_i      (now_tick_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .max_backtrack_o (max_backtrack_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("replay_window_checker_unit regression: fail");
    $finish;
  end

  function automatic verdict_t predict_verdict(input logic [rwc_pkg::ID_W-1:0] id,
                                               input logic [rwc_pkg::TICK_W-1:0] tick);
    verdict_t                   v;
    logic [rwc_pkg::TICK_W-1:0] diff;
    logic [rwc_pkg::ID_W-1:0]   delta;
    logic [rwc_pkg::IDX_W-1:0]  idx;
    v.status = rwc_pkg::ST_ACCEPT;
    diff = tick - expiry_q;
    if (!diff[rwc_pkg::TICK_W-1]) floor_id_q = top_id_q;
    if (id == '0) begin
      v.status = rwc_pkg::ST_ZERO;
    end else if (id > top_id_q) begin
      delta = id - top_id_q;
      if (delta < rwc_pkg::WINDOW_BITS) begin
        base_q = base_q - delta[rwc_pkg::IDX_W-1:0];
        seen_map[base_q] = 1'b1;
        if (extent_q + delta > rwc_pkg::WINDOW_BITS)
          extent_q = rwc_pkg::EXTENT_W'(rwc_pkg::WINDOW_BITS);
        else extent_q = extent_q + delta[rwc_pkg::EXTENT_W-1:0];
        for (int i = 1; i < delta; i++) begin
          idx = base_q + rwc_pkg::IDX_W'(i);
          seen_map[idx] = 1'b0;
        end
      end else begin
        base_q = '0;
        extent_q = rwc_pkg::EXTENT_W'(rwc_pkg::WINDOW_BITS);
        seen_map = '0;
        seen_map[0] = 1'b1;
      end
      top_id_q = id;
    end else begin
      delta = top_id_q - id;
      if (delta > backtrack_q) backtrack_q = delta;
      if (delta >= extent_q || id <= floor_id_q) begin
        v.status = rwc_pkg::ST_OLD;
      end else begin
        idx = base_q + delta[rwc_pkg::IDX_W-1:0];
        if (seen_map[idx]) v.status = rwc_pkg::ST_SEEN;
        else seen_map[idx] = 1'b1;
      end
    end
    if (v.status == rwc_pkg::ST_ACCEPT) expiry_q = tick + expire_ticks_q;
    v.max_backtrack = backtrack_q;
    return v;
  endfunction

  function automatic int draw_wait();
    return steady_flow ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [rwc_pkg::ID_W-1:0] pick_packet_id();
    longint hi;
    longint d;
    longint cand;
    int     sel;
    bit     fwd;
    hi = top_id_q;
    sel = $urandom_range(0, 99);
    fwd = 1'b1;
    d = 1;
    if (sel < 25) d = 1;
    else if (sel < 39) d = $urandom_range(2, 64);
    else if (sel < 47) d = $urandom_range(65, rwc_pkg::WINDOW_BITS - 1);
    else if (sel < 50) d = $urandom_range(rwc_pkg::WINDOW_BITS, rwc_pkg::WINDOW_BITS + 1000000);
    else if (sel < 70) begin fwd = 1'b0; d = $urandom_range(0, 63); end
    else if (sel < 82) begin fwd = 1'b0; d = $urandom_range(64, rwc_pkg::WINDOW_BITS + 52); end
    else if (sel < 87) begin fwd = 1'b0; d = longint'($urandom) % (hi + 1); end
    else if (sel < 92) return '0;
    else if (sel < 95) return $urandom;
    if (fwd) begin
      cand = hi + d;
      if (cand > 64'hFFFF_FFFF) begin
        fwd = 1'b0;
        d = $urandom_range(0, 63);
      end
    end
    if (!fwd) cand = (d < hi) ? hi - d : hi;
    return cand[rwc_pkg::ID_W-1:0];
  endfunction

  task automatic send_request(input logic [rwc_pkg::ID_W-1:0] id,
                              input logic [rwc_pkg::TICK_W-1:0] tick);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    packet_id_i <= id;
    now_tick_i  <= tick;
    pending_verdicts.push_back(predict_verdict(id, tick));
    request_count++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_expire_ticks(input logic [rwc_pkg::TICK_W-1:0] value);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    expire_ticks_q = value;
    setting_count++;
  endtask

  task automatic test_first_packets();
    send_request('0, tick_q);
    send_request(32'd1, tick_q);
    send_request(32'd1, tick_q);
  endtask

  task automatic test_window_slide();
    tick_q += 10;
    send_request(top_id_q + 1, tick_q);
    send_request(top_id_q + 1, tick_q);
    send_request(top_id_q + 100, tick_q);
    send_request(top_id_q - 50, tick_q);
    send_request(top_id_q, tick_q);
    send_request(top_id_q - 200, tick_q);
    send_request(top_id_q + 5000, tick_q);
    send_request(top_id_q - (rwc_pkg::WINDOW_BITS - 1), tick_q);
    send_request(top_id_q - rwc_pkg::WINDOW_BITS, tick_q);
    send_request(top_id_q + (rwc_pkg::WINDOW_BITS - 1), tick_q);
    send_request(top_id_q + rwc_pkg::WINDOW_BITS, tick_q);
  endtask

  task automatic test_floor_expiry();
    logic [rwc_pkg::TICK_W-1:0] t0;
    tick_q += 100;
    t0 = tick_q;
    send_request(top_id_q + 3000, t0);
    send_request('0, t0 + expire_ticks_q - 1);
    send_request(top_id_q - 2, t0 + expire_ticks_q);
    tick_q = t0 + expire_ticks_q;
  endtask

  task automatic test_tick_wrap();
    tick_q = 32'hFFFF_FF00;
    send_request(top_id_q + 2500, tick_q);
    tick_q = 32'h0000_0100;
    send_request(top_id_q - 3, tick_q);
    tick_q = 32'h0000_0900;
    send_request(top_id_q - 4, tick_q);
  endtask

  task automatic test_expire_extremes();
    write_expire_ticks('0);
    send_request(top_id_q + 1, tick_q);
    send_request(top_id_q - 5, tick_q);
    write_expire_ticks('1);
    tick_q += 7;
    send_request(top_id_q + 1, tick_q);
    send_request(top_id_q - 3, tick_q);
  endtask

  task automatic test_random_traffic();
    logic [rwc_pkg::TICK_W-1:0] settings[6];
    int                         sel;
    settings = '{rwc_pkg::EXPIRE_TICKS_RESET, rwc_pkg::TICK_W'($urandom_range(0, 4000)),
                 '0, '1, $urandom, rwc_pkg::TICK_W'(64)};
    for (int p = 0; p < 6; p++) begin
      write_expire_ticks(settings[p]);
      for (int n = 0; n < 112; n++) begin
        if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        sel = $urandom_range(0, 99);
        if (sel < 80) tick_q += $urandom_range(0, 30);
        else if (sel < 95) tick_q += $urandom_range(1800, 2100);
        else if (sel < 98) tick_q += $urandom_range(0, 32'h7FFF_FFFF);
        else tick_q = $urandom;
        send_request(pick_packet_id(), tick_q);
      end
      steady_flow = 1'b0;
    end
  endtask

  task automatic test_top_of_range();
    tick_q += 5;
    send_request('1, tick_q);
    send_request('1, tick_q);
    send_request(32'hFFFF_FFFE, tick_q);
    send_request(32'd1, tick_q);
  endtask

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int stall;
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      status_hits[status_o]++;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: status %0d, max_backtrack %0d", status_o, max_backtrack_o);
        mismatch_count++;
      end else begin
        v = pending_verdicts.pop_front();
        if (status_o !== v.status) begin
          $error("status: expected %0d, actual %0d", v.status, status_o);
          mismatch_count++;
        end
        if (max_backtrack_o !== v.max_backtrack) begin
          $error("max_backtrack: expected %0d, actual %0d", v.max_backtrack, max_backtrack_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_packets();
    test_window_slide();
    test_floor_expiry();
    test_tick_wrap();
    test_expire_extremes();
    test_random_traffic();
    test_top_of_range();
    settle_block();
    repeat (16) @(posedge clk_i);
    $display("covered %0d requests over %0d expiry settings", request_count, setting_count);
    $display("results: %0d accepted, %0d zero, %0d replayed, %0d stale",
             status_hits[rwc_pkg::ST_ACCEPT], status_hits[rwc_pkg::ST_ZERO],
             status_hits[rwc_pkg::ST_SEEN], status_hits[rwc_pkg::ST_OLD]);
    if (mismatch_count == 0 && pending_verdicts.size() == 0)
      $display("replay_window_checker_unit regression: pass");
    else
      $display("replay_window_checker_unit regression: fail");
    $finish;
  end

endmodule

@@ replay_window_checker_unit.f @@
+incdir+hw/rtl
hw/rtl/rwc_pkg.sv
hw/rtl/rwc_bitmap.sv
hw/rtl/rwc_ctrl.sv
hw/rtl/replay_window_checker_unit.sv
dv/tb_replay_window_checker_unit.sv
